@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hdl/dows_pkg.sv @@
// types, constants and length table for the dalvik opcode walk
package dows_pkg;

   localparam int SigOpcodes = 8;
   localparam int SigIdxW    = $clog2(SigOpcodes);
   localparam int CountW     = 4;

   localparam logic [7:0] OpFillArray   = 8'h26;
   localparam logic [7:0] OpPackedSwch  = 8'h2b;
   localparam logic [7:0] OpSparseSwch  = 8'h2c;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusShort   = 2'd1;
   localparam logic [1:0] StatusPayload = 2'd2;

   localparam logic [2:0] UnitLen [256] = '{
      3'd1,3'd1,3'd2,3'd3,3'd1,3'd2,3'd3,3'd1,3'd2,3'd3,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
      3'd1,3'd1,3'd1,3'd2,3'd3,3'd2,3'd2,3'd3,3'd5,3'd2,3'd2,3'd3,3'd2,3'd1,3'd1,3'd2,
      3'd2,3'd1,3'd2,3'd2,3'd3,3'd3,3'd3,3'd1,3'd1,3'd2,3'd3,3'd3,3'd3,3'd2,3'd2,3'd2,
      3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd1,
      3'd1,3'd1,3'd1,3'd1,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,
      3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,
      3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd3,3'd3,
      3'd3,3'd3,3'd3,3'd1,3'd3,3'd3,3'd3,3'd3,3'd3,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
      3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
      3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,
      3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,
      3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
      3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
      3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,
      3'd2,3'd2,3'd2,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
      3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd4,3'd4,3'd3,3'd3,3'd2,3'd2
   };

   typedef struct packed {
      logic [15:0] code_unit;
      logic        first_unit;
      logic        last_unit;
      logic [15:0] method_units;
   } req_item_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [15:0]       sig_01;
      logic [15:0]       sig_23;
      logic [15:0]       sig_45;
      logic [15:0]       sig_67;
      logic [CountW-1:0] opcodes_found;
   } rsp_item_type;

   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctrl_type;

   function automatic logic has_payload(input logic [7:0] op);
      return (op == OpFillArray) || (op == OpPackedSwch) || (op == OpSparseSwch);
   endfunction

endpackage

@@ hdl/dows_req_if.sv @@
// request channel: code units with framing flags
interface dows_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        first_unit;
   logic        last_unit;
   logic [15:0] method_units;

   modport source (output valid, output code_unit, output first_unit, output last_unit,
                   output method_units, input ready);
   modport sink   (input valid, input code_unit, input first_unit, input last_unit,
                   input method_units, output ready);
endinterface

@@ hdl/dows_rsp_if.sv @@
// response channel: status, opcode signatures and count
interface dows_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] sig_01;
   logic [15:0] sig_23;
   logic [15:0] sig_45;
   logic [15:0] sig_67;
   logic [3:0]  opcodes_found;

   modport source (output valid, output status, output sig_01, output sig_23,
                   output sig_45, output sig_67, output opcodes_found, input ready);
   modport sink   (input valid, input status, input sig_01, input sig_23,
                   input sig_45, input sig_67, input opcodes_found, output ready);
endinterface

@@ hdl/dows_in_stage.sv @@
// input register for incoming code units
module dows_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  dows_pkg::req_item_type in_item,
   input  logic                  take,
   output dows_pkg::stage_ctrl_type ctrl,
   output dows_pkg::req_item_type item
);
   import dows_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign in_ready = !valid_ff || take;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign ctrl.valid = valid_ff;
   assign ctrl.last  = item_ff.last_unit;
   assign item       = item_ff;

endmodule

@@ hdl/dows_walk.sv @@
// instruction walk state, payload offset checks and result build
module dows_walk #(
   parameter int MAX_METHOD_UNITS = 65535
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  dows_pkg::req_item_type item,
   output dows_pkg::rsp_item_type result
);
   import dows_pkg::*;

   `include "assert_macros.svh"

   localparam logic [15:0] MaxUnits = 16'(MAX_METHOD_UNITS);

   logic [15:0]       pos_ff, pos_in, pos_e;
   logic [15:0]       len_ff, len_in;
   logic [15:0]       end_ff, end_in;
   logic [15:0]       start_ff, start_in;
   logic [2:0]        left_ff, left_in;
   logic [7:0]        op_ff, op_in;
   logic [15:0]       low_ff, low_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [7:0]        store_ff [SigOpcodes];
   logic [7:0]        store_in [SigOpcodes];
   logic              walking_ff, walking_in;
   logic              error_ff, error_in;
   logic [15:0]       mu_c;
   logic [7:0]        op_new;
   logic [2:0]        len_new;
   logic [31:0]       raw;
   logic [33:0]       pstart;
   logic              rec;
   logic [7:0]        rec_op;
   logic [1:0]        status;

   always_comb begin
      mu_c = (item.method_units > MaxUnits) ? MaxUnits : item.method_units;
      pos_e      = item.first_unit ? '0 : pos_ff;
      len_in     = item.first_unit ? mu_c : len_ff;
      end_in     = item.first_unit ? mu_c : end_ff;
      start_in   = item.first_unit ? '0 : start_ff;
      left_in    = item.first_unit ? '0 : left_ff;
      op_in      = item.first_unit ? '0 : op_ff;
      low_in     = item.first_unit ? '0 : low_ff;
      count_in   = item.first_unit ? '0 : count_ff;
      walking_in = item.first_unit | walking_ff;
      error_in   = item.first_unit ? 1'b0 : error_ff;
      for (int i = 0; i < SigOpcodes; i++) begin
         store_in[i] = item.first_unit ? 8'h00 : store_ff[i];
      end
      op_new  = item.code_unit[7:0];
      len_new = UnitLen[op_new];
      raw     = {item.code_unit, low_in};
      pstart  = {18'b0, start_in} + {{2{raw[31]}}, raw};
      rec     = 1'b0;
      rec_op  = op_in;

      if (walking_in) begin
         if (left_in == 3'd0) begin
            if (({1'b0, pos_e} + 17'(len_new)) > {1'b0, end_in}) begin
               walking_in = 1'b0;
            end else begin
               start_in = pos_e;
               op_in    = op_new;
               left_in  = len_new - 3'd1;
               if (!has_payload(op_new)) begin
                  rec    = 1'b1;
                  rec_op = op_new;
               end
            end
         end else begin
            if (has_payload(op_in)) begin
               if (left_in == 3'd2) begin
                  low_in = item.code_unit;
               end else if (left_in == 3'd1) begin
                  if (pstart[33] || (pstart[32:16] != '0) || (pstart[15:0] >= len_in)) begin
                     error_in   = 1'b1;
                     walking_in = 1'b0;
                  end else begin
                     if (pstart[15:0] < end_in) begin
                        end_in = pstart[15:0];
                     end
                     rec    = 1'b1;
                     rec_op = op_in;
                  end
               end
            end
            left_in = left_in - 3'd1;
         end
      end

      if (rec) begin
         if (count_in < CountW'(SigOpcodes)) begin
            store_in[count_in[SigIdxW-1:0]] = rec_op;
         end
         count_in = count_in + 1'b1;
         if (count_in >= CountW'(SigOpcodes)) begin
            walking_in = 1'b0;
         end
      end

      pos_in = (pos_e == 16'hffff) ? pos_e : pos_e + 16'd1;
      if (item.last_unit) begin
         walking_in = 1'b0;
      end

      if (error_in) begin
         status = StatusPayload;
      end else if (count_in < CountW'(SigOpcodes)) begin
         status = StatusShort;
      end else begin
         status = StatusOk;
      end
      result.status        = status;
      result.sig_01        = (status == StatusOk) ? {store_in[1], store_in[0]} : 16'h0;
      result.sig_23        = (status == StatusOk) ? {store_in[3], store_in[2]} : 16'h0;
      result.sig_45        = (status == StatusOk) ? {store_in[5], store_in[4]} : 16'h0;
      result.sig_67        = (status == StatusOk) ? {store_in[7], store_in[6]} : 16'h0;
      result.opcodes_found = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         len_ff     <= '0;
         end_ff     <= '0;
         start_ff   <= '0;
         left_ff    <= '0;
         op_ff      <= '0;
         low_ff     <= '0;
         count_ff   <= '0;
         walking_ff <= 1'b0;
         error_ff   <= 1'b0;
         for (int i = 0; i < SigOpcodes; i++) begin
            store_ff[i] <= 8'h00;
         end
      end else if (take) begin
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         end_ff     <= end_in;
         start_ff   <= start_in;
         left_ff    <= left_in;
         op_ff      <= op_in;
         low_ff     <= low_in;
         count_ff   <= count_in;
         walking_ff <= walking_in;
         error_ff   <= error_in;
         for (int i = 0; i < SigOpcodes; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CountW'(SigOpcodes))
   `ASSERT_IMPLIES(a_full_stops, clock, reset, count_ff == CountW'(SigOpcodes), !walking_ff)
   `ASSERT_ALWAYS(a_end_in_method, clock, reset, end_ff <= len_ff)

endmodule

@@ hdl/dows_out_stage.sv @@
// result register and step control
module dows_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  dows_pkg::stage_ctrl_type ctrl,
   input  dows_pkg::rsp_item_type   result,
   output logic                     take,
   output logic                     out_valid,
   input  logic                     out_ready,
   output dows_pkg::rsp_item_type   out_item
);
   import dows_pkg::*;

   `include "assert_macros.svh"

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // a unit that yields no result moves on even while the output waits
   assign take     = ctrl.valid && (!ctrl.last || !valid_ff || out_ready);
   assign valid_in = (take && ctrl.last) ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take && ctrl.last) begin
         item_ff <= result;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   `ASSERT_NEXT(a_last_loads, clock, reset, take && ctrl.last, valid_ff)

endmodule

@@ hdl/dalvik_opcode_walk_signature.sv @@
// top level of the dalvik opcode walk signature block
// a result: the last unit passes through the input register, then its result is held in the output register
// throughput: one code unit per cycle unless a stalled result holds back a last unit
// units that yield no result do not wait on rsp, but a held-back last unit also stops the units behind it
// reset (synchronous, active high) clears the walk state and both stage valids
module dalvik_opcode_walk_signature #(
   parameter int MAX_METHOD_UNITS = 65535
) (
   input logic         clock,
   input logic         reset,
   dows_req_if.sink    req_ch,
   dows_rsp_if.source  rsp_ch
);
   import dows_pkg::*;

   req_item_type   in_item;
   req_item_type   item;
   stage_ctrl_type ctrl;
   rsp_item_type   result;
   rsp_item_type   out_item;
   logic           take;

   assign in_item.code_unit    = req_ch.code_unit;
   assign in_item.first_unit   = req_ch.first_unit;
   assign in_item.last_unit    = req_ch.last_unit;
   assign in_item.method_units = req_ch.method_units;

   dows_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .in_item  (in_item),
      .take     (take),
      .ctrl     (ctrl),
      .item     (item)
   );

   dows_walk #(
      .MAX_METHOD_UNITS (MAX_METHOD_UNITS)
   ) u_walk (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .item   (item),
      .result (result)
   );

   dows_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .result    (result),
      .take      (take),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (out_item)
   );

   assign rsp_ch.status        = out_item.status;
   assign rsp_ch.sig_01        = out_item.sig_01;
   assign rsp_ch.sig_23        = out_item.sig_23;
   assign rsp_ch.sig_45        = out_item.sig_45;
   assign rsp_ch.sig_67        = out_item.sig_67;
   assign rsp_ch.opcodes_found = out_item.opcodes_found;

endmodule
